// ===== rtl/core/avo_pkg.sv =====
// Shared types, constants and the sine table generator for the additive
// vibrato oscillator. Used by every module of the block; no dependencies.
`default_nettype none

package avo_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned MAX_HARMONICS_DEF   = 8;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  // Fixed field widths
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned AMP_W   = 15;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned GAINS_W = 64;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SINE_W  = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP            = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_GAINS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIBRATO_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIBRATO_DEPTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VIBRATO_RATE   = 3'd6;

  localparam logic [STEP_W-1:0] FREQ_STEP_RST = 31'd42852281;
  localparam logic [AMP_W-1:0]  AMP_RST       = 15'd3277;

  // Shared multiplier: unsigned operand times signed operand
  localparam int unsigned MUL_A_W = 31;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned PROD_W  = MUL_A_W + 1 + MUL_B_W;

  // Accumulator, Q36 sum of all terms
  localparam int unsigned ACC_W    = 44;
  localparam int unsigned OUT_SHIFT = 21;

  // Divider for the harmonic 1/h scaling, four quotient bits per cycle
  localparam int unsigned DIV_W     = 40;
  localparam int unsigned DVSR_W    = 4;
  localparam int unsigned DIV_RADIX = 4;
  localparam int unsigned DIV_STEPS = DIV_W / DIV_RADIX;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam longint HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FUND_RD,
    ST_FUND_MUL,
    ST_FUND_ACC,
    ST_HARM_CHK,
    ST_HARM_MUL,
    ST_HARM_START,
    ST_HARM_DIV,
    ST_VIB_RD,
    ST_VIB_MUL,
    ST_DONE
  } state_e;

  // Quarter-wave entry i: round(32767*sin(pi/2*i/2^bits)) from a Q30
  // Taylor series, evaluated at elaboration only.
  function automatic logic [AMP_W-1:0] sine_entry(input int unsigned idx,
                                                  input int unsigned bits);
    longint x;
    longint x2;
    longint term;
    longint acc;
    longint r;
    x    = (HALF_PI_Q30 * longint'(idx)) >>> bits;
    x2   = (x * x) >>> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >>> 30) / 6;
    acc  = acc - term;
    term = ((term * x2) >>> 30) / 20;
    acc  = acc + term;
    term = ((term * x2) >>> 30) / 42;
    acc  = acc - term;
    term = ((term * x2) >>> 30) / 72;
    acc  = acc + term;
    term = ((term * x2) >>> 30) / 110;
    acc  = acc - term;
    term = ((term * x2) >>> 30) / 156;
    acc  = acc + term;
    if (acc < 0) begin
      acc = 0;
    end
    r = (acc * 32767 + (longint'(1) <<< 29)) >>> 30;
    if (r > 32767) begin
      r = 32767;
    end
    return r[AMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/avo_sine.sv =====
// Quarter-wave sine lookup with registered table read.
// Depends on avo_pkg for widths and the table generator.
`default_nettype none

module avo_sine import avo_pkg::*; #(
  parameter int unsigned TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic [PHASE_W-1:0]       phase_i,
  output logic signed [SINE_W-1:0]      sine_o
);

  localparam int unsigned QSIZE  = 1 << TABLE_BITS;
  localparam int unsigned ADDR_W = TABLE_BITS + 1;

  logic [AMP_W-1:0]      rom [QSIZE+1];
  logic [TABLE_BITS+1:0] idx;
  logic [TABLE_BITS-1:0] k;
  logic [ADDR_W-1:0]     addr;
  logic [AMP_W-1:0]      entry_q;
  logic                  neg_q;

  for (genvar i = 0; i <= QSIZE; i++) begin : g_rom
    assign rom[i] = sine_entry(i, TABLE_BITS);
  end

  assign idx  = phase_i[PHASE_W-1 -: TABLE_BITS+2];
  assign k    = idx[TABLE_BITS-1:0];
  // Mirror the index in odd quadrants
  assign addr = idx[TABLE_BITS] ? (ADDR_W'(QSIZE) - {1'b0, k}) : {1'b0, k};

  always_ff @(posedge clk_i) begin
    entry_q <= rom[addr];
    neg_q   <= idx[TABLE_BITS+1];
  end

  assign sine_o = neg_q ? -$signed({1'b0, entry_q}) : $signed({1'b0, entry_q});

endmodule

`default_nettype wire

// ===== rtl/core/avo_div.sv =====
// Radix-16 restoring divider for a wide magnitude by a small divisor.
// Depends on avo_pkg for widths; four quotient bits per cycle.
`default_nettype none

module avo_div import avo_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_W-1:0]  dividend_i,
  input  wire logic [DVSR_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DIV_W-1:0]       quotient_o
);

  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DVSR_W-1:0]    rem_q, rem_d;
  logic [DVSR_W-1:0]    dvsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  always_comb begin
    logic [DVSR_W:0] r;
    r     = {1'b0, rem_q};
    quo_d = quo_q;
    for (int s = 0; s < DIV_RADIX; s++) begin
      r     = {r[DVSR_W-1:0], quo_d[DIV_W-1]};
      quo_d = {quo_d[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dvsr_q}) begin
        r        = r - {1'b0, dvsr_q};
        quo_d[0] = 1'b1;
      end
    end
    rem_d = r[DVSR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/additive_vibrato_oscillator.sv =====
// Top level of the additive vibrato oscillator: configuration registers,
// sequencer and shared multiplier. Depends on avo_pkg, avo_sine and avo_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o, payload restart_i): each
//   transaction is one sample tick. restart_i = 1 clears the main, vibrato
//   and time phases before the tick is computed.
//   Output channel (out_valid_o / out_stall_i, payload sample_o): one signed
//   Q1.15 sample per input transaction, in order.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 freq_step .. 6 vibrato_rate_step); other indexes are dropped.
//   Write only while the block is idle.
//   Each harmonic that passes the count and Nyquist checks (0..MAX_HARMONICS
//   of them per tick) costs a table read, two passes through the shared
//   multiplier and a run of the radix-16 divider that applies the 1/h
//   scaling. in_stall_o is high while a tick is in work.
//   The result sits in an output register, so the next tick is accepted
//   while a sample still waits; if out_stall_i holds that sample, the next
//   tick finishes its arithmetic and waits in the final state.
//   Reset: all phases clear, state and configuration registers take their reset values, no output.
`default_nettype none

module additive_vibrato_oscillator import avo_pkg::*; #(
  parameter int unsigned MAX_HARMONICS   = MAX_HARMONICS_DEF,
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  restart_i,
  // Output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  // Configuration port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Harmonic counter must reach MAX_HARMONICS + 1
  localparam int unsigned H_W = $clog2(MAX_HARMONICS + 2);
  localparam int unsigned NYQ_W = STEP_W + 4;
  localparam int unsigned S_W = ACC_W - OUT_SHIFT;

  // Configuration registers
  logic [STEP_W-1:0]  freq_step_q;
  logic [AMP_W-1:0]   amp_q;
  logic [CNT_W-1:0]   harmonic_count_q;
  logic [GAINS_W-1:0] harmonic_gains_q;
  logic               vibrato_enable_q;
  logic [STEP_W-1:0]  vibrato_depth_q;
  logic [STEP_W-1:0]  vibrato_rate_q;

  // Oscillator state
  logic [PHASE_W-1:0] main_phase_q, main_phase_d;
  logic [PHASE_W-1:0] vib_phase_q, vib_phase_d;
  logic [PHASE_W-1:0] time_phase_q, time_phase_d;

  // Sequencer and datapath registers
  state_e                    state_q, state_d;
  logic [H_W-1:0]            h_q, h_d;
  logic [PHASE_W-1:0]        hph_q, hph_d;
  logic [NYQ_W-1:0]          nyq_q, nyq_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;

  // Shared units
  logic [PHASE_W-1:0]       sine_phase;
  logic signed [SINE_W-1:0] sine;
  logic [MUL_A_W-1:0]       mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;
  logic                     prod_neg;
  logic [PROD_W-1:0]        prod_mag;

  logic                     in_accept;
  logic                     out_free;
  logic [H_W-1:0]           count_eff;
  logic [GAINS_W-1:0]       gains_shifted;
  logic [GAIN_W-1:0]        gain;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_biased;
  logic signed [S_W-1:0]    s_trunc;
  logic signed [SAMPLE_W-1:0] s_sat;
  logic signed [PROD_W-1:0] vib_biased;
  logic [PHASE_W-1:0]       vib_off;
  logic [PHASE_W-1:0]       main_step;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Clamp the harmonic count to what the block supports
  assign count_eff = (harmonic_count_q > CNT_W'(MAX_HARMONICS)) ?
                     H_W'(MAX_HARMONICS) : H_W'(harmonic_count_q);

  assign gains_shifted = harmonic_gains_q >> (GAIN_W * (32'(h_q) - 32'd1));
  assign gain          = gains_shifted[GAIN_W-1:0];

  // Shared multiplier
  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // Harmonic term: magnitude goes through the divider, sign is restored
  assign prod_neg = prod_q[PROD_W-1];
  assign prod_mag = prod_neg ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign term     = prod_neg ? -$signed({4'b0, div_quo}) : $signed({4'b0, div_quo});

  // Output: truncate toward zero, then saturate
  assign acc_biased = acc_q + (acc_q[ACC_W-1] ? ACC_W'((1 << OUT_SHIFT) - 1) : ACC_W'(0));
  assign s_trunc    = S_W'(acc_biased >>> OUT_SHIFT);
  always_comb begin
    if (s_trunc > S_W'(32767)) begin
      s_sat = 16'sh7fff;
    end else if (s_trunc < -S_W'(32768)) begin
      s_sat = -16'sh8000;
    end else begin
      s_sat = SAMPLE_W'(s_trunc);
    end
  end

  // Vibrato offset: divide by 2^15 truncating toward zero
  assign vib_biased = prod_q + (prod_neg ? PROD_W'(32767) : PROD_W'(0));
  assign vib_off    = PHASE_W'(vib_biased >>> 15);
  assign main_step  = {1'b0, freq_step_q} + (vibrato_enable_q ? vib_off : PHASE_W'(0));

  avo_sine #(
    .TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine (
    .clk_i  (clk_i),
    .phase_i(sine_phase),
    .sine_o (sine)
  );

  avo_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_mag[DIV_W-1:0]),
    .divisor_i (DVSR_W'(h_q)),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    h_d          = h_q;
    hph_d        = hph_q;
    nyq_d        = nyq_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    main_phase_d = main_phase_q;
    vib_phase_d  = vib_phase_q;
    time_phase_d = time_phase_q;
    out_valid_d  = out_valid_q && out_stall_i;
    sample_d     = sample_q;
    sine_phase   = main_phase_q;
    mul_a        = MUL_A_W'(amp_q);
    mul_b        = sine;
    div_start    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (restart_i) begin
            main_phase_d = '0;
            vib_phase_d  = '0;
            time_phase_d = '0;
          end
          state_d = ST_FUND_RD;
        end
      end
      ST_FUND_RD: begin
        sine_phase = main_phase_q;
        state_d    = ST_FUND_MUL;
      end
      ST_FUND_MUL: begin
        prod_d  = mul_p;
        state_d = ST_FUND_ACC;
      end
      ST_FUND_ACC: begin
        acc_d   = ACC_W'(prod_q) <<< 6;
        h_d     = H_W'(1);
        hph_d   = time_phase_q;
        nyq_d   = NYQ_W'(freq_step_q);
        state_d = ST_HARM_CHK;
      end
      ST_HARM_CHK: begin
        // Stop at the count or the first harmonic at or above Nyquist
        if ((h_q > count_eff) || (nyq_q[NYQ_W-1:STEP_W] != '0)) begin
          state_d = ST_VIB_RD;
        end else begin
          sine_phase = hph_q;
          mul_b      = $signed({{(MUL_B_W-GAIN_W){1'b0}}, gain});
          prod_d     = mul_p;
          state_d    = ST_HARM_MUL;
        end
      end
      ST_HARM_MUL: begin
        mul_a   = MUL_A_W'(prod_q[GAIN_W+AMP_W-1:0]);
        prod_d  = mul_p;
        state_d = ST_HARM_START;
      end
      ST_HARM_START: begin
        div_start = 1'b1;
        state_d   = ST_HARM_DIV;
      end
      ST_HARM_DIV: begin
        if (div_done) begin
          acc_d   = acc_q + term;
          h_d     = h_q + 1'b1;
          hph_d   = hph_q + time_phase_q;
          nyq_d   = nyq_q + NYQ_W'(freq_step_q);
          state_d = ST_HARM_CHK;
        end
      end
      ST_VIB_RD: begin
        sine_phase = vib_phase_q;
        state_d    = ST_VIB_MUL;
      end
      ST_VIB_MUL: begin
        mul_a   = vibrato_depth_q;
        prod_d  = mul_p;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          sample_d     = s_sat;
          main_phase_d = main_phase_q + main_step;
          time_phase_d = time_phase_q + {1'b0, freq_step_q};
          if (vibrato_enable_q) begin
            vib_phase_d = vib_phase_q + {1'b0, vibrato_rate_q};
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      main_phase_q <= '0;
      vib_phase_q  <= '0;
      time_phase_q <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      main_phase_q <= main_phase_d;
      vib_phase_q  <= vib_phase_d;
      time_phase_q <= time_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q      <= h_d;
    hph_q    <= hph_d;
    nyq_q    <= nyq_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    sample_q <= sample_d;
  end

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_step_q      <= FREQ_STEP_RST;
      amp_q            <= AMP_RST;
      harmonic_count_q <= '0;
      harmonic_gains_q <= '0;
      vibrato_enable_q <= 1'b0;
      vibrato_depth_q  <= '0;
      vibrato_rate_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FREQ_STEP:      freq_step_q      <= cfg_data_i[STEP_W-1:0];
        REG_AMP:            amp_q            <= cfg_data_i[AMP_W-1:0];
        REG_HARMONIC_COUNT: harmonic_count_q <= cfg_data_i[CNT_W-1:0];
        REG_HARMONIC_GAINS: harmonic_gains_q <= cfg_data_i[GAINS_W-1:0];
        REG_VIBRATO_ENABLE: vibrato_enable_q <= cfg_data_i[0];
        REG_VIBRATO_DEPTH:  vibrato_depth_q  <= cfg_data_i[STEP_W-1:0];
        REG_VIBRATO_RATE:   vibrato_rate_q   <= cfg_data_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

`default_nettype wire
